FILE: rtl/core/ptc_pkg.sv
// Shared types and constants for the pressure tendency classifier.
// No dependencies; imported by every module of the block except ptc_ram.
`default_nettype none

package ptc_pkg;

   // Ring store geometry
   localparam int WIN_DEPTH = 2048;
   localparam int SLOT_W    = $clog2(WIN_DEPTH);
   localparam int LEN_W     = 12;
   localparam int SAMPLE_W  = 17;
   localparam int CHANGE_W  = 18;
   localparam int THR_W     = 16;
   localparam int CODE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // floor(n/3) = (n * RECIP3) >> RECIP3_SHIFT, exact for n below 8192
   localparam int RECIP3       = 2731;
   localparam int RECIP3_SHIFT = 13;
   localparam int PROD_W       = 2 * LEN_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIX_HOUR_PERIOD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEADY_THRESHOLD = 2'd2;

   // Register reset values
   localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST    = 12'd2048;
   localparam logic [THR_W-1:0] STEADY_THRESHOLD_RST = 16'd100;

   // Tendency codes
   localparam logic [CODE_W-1:0] CODE_TRAINING = 2'd0;
   localparam logic [CODE_W-1:0] CODE_STEADY   = 2'd1;
   localparam logic [CODE_W-1:0] CODE_RISING   = 2'd2;
   localparam logic [CODE_W-1:0] CODE_FALLING  = 2'd3;

   // Request issued from the ring control into the classify stage
   typedef struct packed {
      logic                valid;
      logic                train;
      logic                fwd;
      logic [SAMPLE_W-1:0] sample;
   } issue_type;

endpackage

`default_nettype wire

FILE: rtl/core/ptc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies. Read during a write to the same address returns old data.
`default_nettype none

module ptc_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/ptc_ring_ctrl.sv
// Ring control: config registers, write slot, fill count, training limit
// and ring store addressing. Depends on ptc_pkg.
`default_nettype none

module ptc_ring_ctrl
   import ptc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   input  wire logic                 accept,
   input  wire logic [SAMPLE_W-1:0]  sample,
   output      logic                 ram_wr_en,
   output      logic [SLOT_W-1:0]    ram_wr_addr,
   output      logic [SAMPLE_W-1:0]  ram_wr_data,
   output      logic [SLOT_W-1:0]    ram_rd_addr,
   output      issue_type            issue,
   output      logic [THR_W-1:0]     threshold
);

   logic [LEN_W-1:0]  window_length_ff;
   logic              six_hour_ff;
   logic [THR_W-1:0]  threshold_ff;
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;

   logic [LEN_W-1:0]  eff_len;
   logic [SLOT_W-1:0] slot;
   logic [LEN_W-1:0]  slot_inc;
   logic [LEN_W-1:0]  fill_inc;
   logic [PROD_W-1:0] third_prod;
   logic [LEN_W-1:0]  third;
   logic [LEN_W-1:0]  train_limit;
   logic              full;

   // Effective window: zero counts as one, clamp at the ring depth
   always_comb begin
      if (window_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (window_length_ff > LEN_W'(WIN_DEPTH)) begin
         eff_len = LEN_W'(WIN_DEPTH);
      end else begin
         eff_len = window_length_ff;
      end
   end

   // Slot to write now and the slot after it
   always_comb begin
      slot = ({1'b0, wslot_ff} >= eff_len) ? '0 : wslot_ff;
      slot_inc = {1'b0, slot} + LEN_W'(1);
      wslot_in = (slot_inc >= eff_len) ? '0 : slot_inc[SLOT_W-1:0];
      fill_inc = (fill_ff < eff_len) ? fill_ff + LEN_W'(1) : eff_len;
      fill_in  = fill_inc;
   end

   // Training limit: len/3, or len/6 as (len/3)/2
   always_comb begin
      third_prod  = PROD_W'(eff_len) * PROD_W'(RECIP3);
      third       = LEN_W'(third_prod >> RECIP3_SHIFT);
      train_limit = six_hour_ff ? (third >> 1) : third;
      full        = (fill_inc >= eff_len);
   end

   // Ring access: write the new sample, read the oldest one
   always_comb begin
      ram_wr_en    = accept;
      ram_wr_addr  = slot;
      ram_wr_data  = sample;
      ram_rd_addr  = full ? wslot_in : '0;
      issue.valid  = accept;
      issue.train  = (fill_inc < train_limit);
      issue.fwd    = (ram_rd_addr == slot);
      issue.sample = sample;
      threshold    = threshold_ff;
   end

   // Config registers and ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RST;
         six_hour_ff      <= 1'b0;
         threshold_ff     <= STEADY_THRESHOLD_RST;
         wslot_ff         <= '0;
         fill_ff          <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_wdata[LEN_W-1:0];
               wslot_ff         <= '0;
               fill_ff          <= '0;
            end
            CSR_SIX_HOUR_PERIOD: begin
               six_hour_ff <= csr_wdata[0];
            end
            CSR_STEADY_THRESHOLD: begin
               threshold_ff <= csr_wdata[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         wslot_ff <= wslot_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/ptc_classify.sv
// Classify stage: takes the oldest sample from the ring, forms the change,
// classifies it and queues the response in a two-entry buffer. Depends on ptc_pkg.
`default_nettype none

module ptc_classify
   import ptc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire issue_type                  issue,
   input  wire logic [SAMPLE_W-1:0]        ram_rd_data,
   input  wire logic [THR_W-1:0]           threshold,
   output      logic                       req_ready,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [CODE_W-1:0]          rsp_tendency_code,
   output      logic signed [CHANGE_W-1:0] rsp_pressure_change
);

   issue_type s1_ff;

   logic [SAMPLE_W-1:0]        oldest;
   logic signed [CHANGE_W-1:0] delta;
   logic [SAMPLE_W-1:0]        mag;
   logic [CODE_W-1:0]          code;
   logic signed [CHANGE_W-1:0] change;

   logic [CODE_W-1:0]          q_code_ff   [2];
   logic signed [CHANGE_W-1:0] q_change_ff [2];
   logic                       wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                 count_ff, count_in;
   logic                       pop;
   logic [2:0]                 occ_left;

   // Stage register: lines the request up with the registered ring read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= issue.valid;
      end
      s1_ff.train  <= issue.train;
      s1_ff.fwd    <= issue.fwd;
      s1_ff.sample <= issue.sample;
   end

   // Change and classification; forward the sample when it was just written
   always_comb begin
      oldest = s1_ff.fwd ? s1_ff.sample : ram_rd_data;
      delta  = $signed({1'b0, s1_ff.sample}) - $signed({1'b0, oldest});
      mag    = delta[CHANGE_W-1] ? SAMPLE_W'(-delta) : delta[SAMPLE_W-1:0];
      priority if (s1_ff.train) begin
         code   = CODE_TRAINING;
         change = '0;
      end else if (mag < {1'b0, threshold} || delta == '0) begin
         code   = CODE_STEADY;
         change = delta;
      end else if (!delta[CHANGE_W-1]) begin
         code   = CODE_RISING;
         change = delta;
      end else begin
         code   = CODE_FALLING;
         change = delta;
      end
   end

   // Response buffer and flow control
   always_comb begin
      pop       = rsp_valid && rsp_ready;
      count_in  = count_ff + {1'b0, s1_ff.valid} - {1'b0, pop};
      occ_left  = {1'b0, count_ff} + {2'b0, s1_ff.valid} - {2'b0, pop};
      req_ready = (occ_left < 3'd2);
      rsp_valid = (count_ff != '0);
      rsp_tendency_code   = q_code_ff[rd_ptr_ff];
      rsp_pressure_change = q_change_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (s1_ff.valid) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
      if (s1_ff.valid) begin
         q_code_ff[wr_ptr_ff]   <= code;
         q_change_ff[wr_ptr_ff] <= change;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/pressure_tendency_classifier_unit.sv
// Top level of the pressure tendency classifier: ring control, ring store
// and classify stage. Depends on ptc_pkg, ptc_ring_ctrl, ptc_ram, ptc_classify.
//
//   Channel  Handshake               Payload
//   req      req_valid / req_ready   req_pressure_sample (17b)
//   rsp      rsp_valid / rsp_ready   rsp_tendency_code (2b), rsp_pressure_change (18b s)
//   csr      csr_wr_en               csr_index (2b), csr_wdata (16b)
//
// One request per cycle while the response buffer has room; at acceptance the
// ring store read and the stage register are loaded, then the response buffer
// is written and the response becomes valid. The ring store has one write and
// one read port, both used once per request. A two-entry response buffer
// keeps requests flowing while a response waits. Reset is synchronous and
// needs no clearing pass: ring entries are always written before being read.
`default_nettype none

module pressure_tendency_classifier_unit
   import ptc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [SAMPLE_W-1:0]        req_pressure_sample,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [CODE_W-1:0]          rsp_tendency_code,
   output      logic signed [CHANGE_W-1:0] rsp_pressure_change,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DAT_W-1:0]       csr_wdata
);

   logic                accept;
   logic                ram_wr_en;
   logic [SLOT_W-1:0]   ram_wr_addr;
   logic [SAMPLE_W-1:0] ram_wr_data;
   logic [SLOT_W-1:0]   ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;
   issue_type           issue;
   logic [THR_W-1:0]    threshold;

   assign accept = req_valid && req_ready;

   ptc_ring_ctrl u_ring_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .sample      (req_pressure_sample),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .issue       (issue),
      .threshold   (threshold)
   );

   ptc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WIN_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptc_classify u_classify (
      .clock               (clock),
      .reset               (reset),
      .issue               (issue),
      .ram_rd_data         (ram_rd_data),
      .threshold           (threshold),
      .req_ready           (req_ready),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tendency_code   (rsp_tendency_code),
      .rsp_pressure_change (rsp_pressure_change)
   );

endmodule

`default_nettype wire

FILE: test/pressure_tendency_classifier_unit_tb.sv
// Testbench for pressure_tendency_classifier_unit: directed and random pressure samples,
// each response checked against a ring-window model kept inside the bench.
// Depends on ptc_pkg and the RTL top module.
`timescale 1ns / 1ps

module pressure_tendency_classifier_unit_tb;
   import ptc_pkg::*;

   localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [CODE_W-1:0]          code;
      logic signed [CHANGE_W-1:0] change;
   } tendency_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [SAMPLE_W-1:0]        req_pressure_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [CODE_W-1:0]          rsp_tendency_code;
   logic signed [CHANGE_W-1:0] rsp_pressure_change;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DAT_W-1:0]       csr_wdata = '0;

   pressure_tendency_classifier_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pressure_sample (req_pressure_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tendency_code   (rsp_tendency_code),
      .rsp_pressure_change (rsp_pressure_change),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 50 MHz clock
   always begin
      #10;
      clock = 1'b1;
      #10;
      clock = 1'b0;
   end

   // Bench copy of the window state and the registers
   logic [SAMPLE_W-1:0] window_copy [WIN_DEPTH];
   int unsigned         held_count = 0;
   int unsigned         next_slot = 0;
   logic [LEN_W-1:0]    len_setting = WINDOW_LENGTH_RST;
   logic                six_hour_setting = 1'b0;
   logic [THR_W-1:0]    threshold_setting = STEADY_THRESHOLD_RST;

   logic [SAMPLE_W-1:0] sample_pending [$];
   tendency_type        tendency_expected [$];

   int req_count = 0;
   int rsp_count = 0;
   int fail_count = 0;
   int settings_count = 0;
   int code_seen [4] = '{0, 0, 0, 0};
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int idle_cycles = 0;
   tendency_type oldest_expected;

   // No idling on either side for a stretch of responses
   wire full_rate = (rsp_count >= 500) && (rsp_count < 700);

   // Register write as the block sees it; a window length write restarts the window
   function automatic void note_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DAT_W-1:0] val);
      case (idx)
         CSR_WINDOW_LENGTH: begin
            len_setting = val[LEN_W-1:0];
            held_count  = 0;
            next_slot   = 0;
         end
         CSR_SIX_HOUR_PERIOD: six_hour_setting = val[0];
         CSR_STEADY_THRESHOLD: threshold_setting = val[THR_W-1:0];
         default: ;
      endcase
   endfunction

   // Store one sample in the window and classify it against the oldest one held
   function automatic tendency_type classify_tendency(input logic [SAMPLE_W-1:0] sample);
      int unsigned         span;
      int unsigned         slot;
      int unsigned         train_limit;
      logic [SAMPLE_W-1:0] oldest;
      int                  delta;
      int                  mag;
      tendency_type        res;
      // window length 0 acts as 1, anything above the store depth as the depth
      if (len_setting == 0)
         span = 1;
      else if (len_setting > WIN_DEPTH)
         span = WIN_DEPTH;
      else
         span = len_setting;
      slot = (next_slot >= span) ? 0 : next_slot;
      window_copy[slot] = sample;
      slot++;
      if (slot >= span)
         slot = 0;
      next_slot = slot;
      if (held_count < span)
         held_count++;
      else
         held_count = span;
      train_limit = six_hour_setting ? span / 6 : span / 3;
      if (held_count < train_limit) begin
         res.code   = CODE_TRAINING;
         res.change = '0;
         return res;
      end
      // oldest is the first sample until the window fills
      oldest = (held_count >= span) ? window_copy[next_slot] : window_copy[0];
      delta  = int'(sample) - int'(oldest);
      mag    = (delta < 0) ? -delta : delta;
      if (mag < int'(threshold_setting) || delta == 0)
         res.code = CODE_STEADY;
      else if (delta > 0)
         res.code = CODE_RISING;
      else
         res.code = CODE_FALLING;
      res.change = CHANGE_W'(delta);
      return res;
   endfunction

   // Request driver: fed from the pending queue, predicts at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            tendency_expected.push_back(classify_tendency(req_pressure_sample));
            req_count <= req_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (sample_pending.size() != 0 && (full_rate || $urandom_range(99) >= 33)) begin
               req_valid           <= 1'b1;
               req_pressure_sample <= sample_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and ready generation, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tendency_expected.size() == 0) begin
               $display("%0t: response with nothing expected: code %0d change %0d",
                        $time, rsp_tendency_code, rsp_pressure_change);
               fail_count++;
            end else begin
               oldest_expected = tendency_expected.pop_front();
               if (rsp_tendency_code !== oldest_expected.code) begin
                  $display("%0t: tendency code mismatch: expected %0d, actual %0d",
                           $time, oldest_expected.code, rsp_tendency_code);
                  fail_count++;
               end
               if (rsp_pressure_change !== oldest_expected.change) begin
                  $display("%0t: pressure change mismatch: expected %0d, actual %0d",
                           $time, oldest_expected.change, rsp_pressure_change);
                  fail_count++;
               end
            end
            code_seen[rsp_tendency_code]++;
            rsp_count <= rsp_count + 1;
         end
         if (!long_hold_done && rsp_count >= 200) begin
            hold_left      = 120;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= full_rate || ($urandom_range(99) >= 33);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles", $time, STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic queue_sample(input logic [SAMPLE_W-1:0] sample);
      sample_pending.push_back(sample);
   endtask

   // Sender holds off until every expected response is back
   task automatic wait_drained();
      do
         @(posedge clock);
      while (sample_pending.size() != 0 || req_valid || tendency_expected.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      note_csr_write(idx, val);
   endtask

   task automatic apply_settings(input logic [CSR_DAT_W-1:0] win_len, input logic six_hour,
                                 input logic [THR_W-1:0] thr, input bit restart);
      wait_drained();
      if (restart)
         write_csr(CSR_WINDOW_LENGTH, win_len);
      write_csr(CSR_SIX_HOUR_PERIOD, CSR_DAT_W'(six_hour));
      write_csr(CSR_STEADY_THRESHOLD, thr);
      settings_count++;
   endtask

   initial begin
      int                  random_total;
      int                  phase;
      int                  n_items;
      int                  step;
      int                  level;
      int                  pick;
      logic [CSR_DAT_W-1:0] win_pick;
      logic                six_pick;
      logic [THR_W-1:0]    thr_pick;
      bit                  restart;
      logic [SAMPLE_W-1:0] sample;

      random_total = 0;
      level        = 101325;
      win_pick     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: long window, still training
      queue_sample('0);
      queue_sample(SAMPLE_W'(SAMPLE_MAX));

      // Window length 0 acts as a window of one; threshold 0 with no change is steady
      apply_settings(0, 1'b0, 0, 1'b1);
      queue_sample(5);
      queue_sample(SAMPLE_W'(SAMPLE_MAX));

      // Two-sample window: no training, change equal to threshold, full-scale swings
      apply_settings(2, 1'b0, 50, 1'b1);
      queue_sample(1000);
      queue_sample(1050);
      queue_sample(1000);
      queue_sample(0);
      queue_sample(SAMPLE_W'(SAMPLE_MAX));
      queue_sample(0);

      // Three-hour training over a window of nine
      apply_settings(9, 1'b0, 1000, 1'b1);
      queue_sample(101325);
      queue_sample(101400);
      queue_sample(102500);
      queue_sample(100000);

      // Rewriting the window length restarts training
      apply_settings(9, 1'b0, 1000, 1'b1);
      queue_sample(101000);
      queue_sample(101500);

      // Six-hour training, largest threshold
      apply_settings(12, 1'b1, 16'hFFFF, 1'b1);
      queue_sample(0);
      queue_sample(SAMPLE_W'(SAMPLE_MAX));
      queue_sample(65000);

      // Six-hour period on a window too short to train
      apply_settings(5, 1'b1, 200, 1'b1);
      queue_sample(500);
      queue_sample(600);

      // Random phases; the first one uses an oversized window that clamps to the depth
      for (phase = 0; random_total < 1080; phase++) begin
         if (phase == 0) begin
            win_pick = 16'd4095;
            six_pick = 1'b1;
            thr_pick = THR_W'($urandom_range(300, 50));
            restart  = 1'b1;
            n_items  = 360;
         end else begin
            pick = $urandom_range(9);
            if (pick == 0)
               win_pick = 0;
            else if (pick == 1)
               win_pick = 1;
            else if (pick == 2)
               win_pick = CSR_DAT_W'($urandom_range(7, 2));
            else
               win_pick = CSR_DAT_W'($urandom_range(48, 8));
            six_pick = 1'($urandom_range(1));
            pick     = $urandom_range(9);
            if (pick == 0)
               thr_pick = '0;
            else if (pick == 1)
               thr_pick = '1;
            else if (pick == 2)
               thr_pick = THR_W'($urandom);
            else
               thr_pick = THR_W'($urandom_range(400, 1));
            restart = ($urandom_range(9) >= 3);
            n_items = $urandom_range(60, 10);
         end
         apply_settings(win_pick, six_pick, thr_pick, restart);
         // drift size near the threshold so steady and moving both show up
         step = (thr_pick < 1000) ? int'(thr_pick) + 20 : 500;
         for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
               sample = SAMPLE_W'($urandom);
            end else if (pick == 1) begin
               sample = $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            end else begin
               level += int'($urandom_range(2 * step)) - step;
               if (level < 0)
                  level = 0;
               if (level > SAMPLE_MAX)
                  level = SAMPLE_MAX;
               sample = SAMPLE_W'(level);
            end
            queue_sample(sample);
         end
         random_total += n_items;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Ran %0d requests and %0d responses across %0d register settings",
               req_count, rsp_count, settings_count);
      $display("Tendencies seen: training %0d, steady %0d, rising %0d, falling %0d",
               code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
